// ----- rtl/vrp_pkg.sv -----
// Shared constants and types for the vertex rotate and project block.
`timescale 1ns / 1ps
`default_nettype none
package vrp_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int ANGLE_BITS_DEF  = 12;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ANGLE_W    = 12;
	localparam int DEPTH_W    = 16;
	localparam int SCALE_W    = 16;
	localparam int CENTER_W   = 10;
	localparam int TRIG_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_X      = 3'd0,
		REG_ANGLE_Y      = 3'd1,
		REG_ANGLE_Z      = 3'd2,
		REG_CAMERA_DEPTH = 3'd3,
		REG_SCALE_H      = 3'd4,
		REG_SCALE_V      = 3'd5,
		REG_CENTER_H     = 3'd6,
		REG_CENTER_V     = 3'd7
	} reg_idx_t;

	localparam logic [DEPTH_W-1:0]  CAMERA_DEPTH_RST = 16'd1280;
	localparam logic [SCALE_W-1:0]  SCALE_H_RST      = 16'd17067;
	localparam logic [SCALE_W-1:0]  SCALE_V_RST      = 16'd14895;
	localparam logic [CENTER_W-1:0] CENTER_H_RST     = 10'd64;
	localparam logic [CENTER_W-1:0] CENTER_V_RST     = 10'd32;

	// quarter-wave sine polynomial, Q14
	localparam logic [14:0] SIN_A   = 15'd25736;
	localparam logic [13:0] SIN_B   = 14'd10512;
	localparam logic [10:0] SIN_C   = 11'd1160;
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	// cycles the input is held off after a register write, while the trig pipelines settle
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_x;
		logic signed [TRIG_W-1:0] cos_x;
		logic signed [TRIG_W-1:0] sin_y;
		logic signed [TRIG_W-1:0] cos_y;
		logic signed [TRIG_W-1:0] sin_z;
		logic signed [TRIG_W-1:0] cos_z;
		logic signed [DEPTH_W-1:0] camera_depth;
		logic [SCALE_W-1:0]        scale_h;
		logic [SCALE_W-1:0]        scale_v;
		logic [CENTER_W-1:0]       center_h;
		logic [CENTER_W-1:0]       center_v;
	} coef_t;

endpackage
`default_nettype wire

// ----- rtl/vertex_rotate_project.sv -----
// Top level of the vertex rotate and project block.
// Rotates each Q8.8 vertex about Z, Y, X, takes the view depth as camera depth minus
// Z, scales and divides by view depth, and gives Q12.4 screen coordinates. One vertex
// per clock sustained while the result queue has room; the divider is a one-bit-per-stage
// pipeline of NB (COORD_WIDTH + 22 bits) stages. After reset or any register write,
// full stays high while the sine pipelines settle.
`timescale 1ns / 1ps
`default_nettype none
module vertex_rotate_project #(
	parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_BITS  = vrp_pkg::ANGLE_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [vrp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [vrp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             push,
	output logic                            full,
	input  wire  signed [COORD_WIDTH-1:0]   vertex_x,
	input  wire  signed [COORD_WIDTH-1:0]   vertex_y,
	input  wire  signed [COORD_WIDTH-1:0]   vertex_z,
	output logic                            empty,
	input  wire                             pop,
	output logic signed [COORD_WIDTH-1:0]   screen_x,
	output logic signed [COORD_WIDTH-1:0]   screen_y,
	output logic signed [COORD_WIDTH-1:0]   view_depth,
	output logic                            behind_camera
);
	logic                     f_valid, f_take;
	logic [3*COORD_WIDTH-1:0] f_data;
	vrp_pkg::coef_t           coef;

	vrp_front #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.f_valid(f_valid), .f_take(f_take), .f_data(f_data), .coef(coef));

	vrp_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.f_valid(f_valid), .f_take(f_take), .f_data(f_data), .coef(coef),
		.empty(empty), .pop(pop),
		.screen_x(screen_x), .screen_y(screen_y),
		.view_depth(view_depth), .behind_camera(behind_camera));
endmodule
`default_nettype wire

// ----- rtl/vrp_sine.sv -----
// Pipelined Q14 sine of an angle, four register stages.
`timescale 1ns / 1ps
`default_nettype none
module vrp_sine #(
	parameter int ANGLE_BITS = vrp_pkg::ANGLE_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  [ANGLE_BITS-1:0]              angle,
	output logic signed [vrp_pkg::TRIG_W-1:0]  sine
);
	logic [1:0]  quad;
	logic [14:0] u0, uu;
	logic [29:0] sq;
	logic [14:0] u_s1, u2_s1, u_s2, u2_s2, u_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [25:0] c_prod;
	logic [13:0] t1_s2;
	logic [27:0] b_prod;
	logic [14:0] t2_s3;
	logic [29:0] a_prod;
	logic [15:0] mag;

	assign quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
	assign u0   = 15'(angle[ANGLE_BITS-3:0]) << (16 - ANGLE_BITS);
	assign uu   = quad[0] ? (vrp_pkg::ONE_Q14 - u0) : u0;
	assign sq   = uu * uu;

	assign c_prod = vrp_pkg::SIN_C * u2_s1;
	assign b_prod = t1_s2 * u2_s2;
	assign a_prod = t2_s3 * u_s3;
	assign mag    = (a_prod[29:14] > 16'(vrp_pkg::ONE_Q14)) ? 16'(vrp_pkg::ONE_Q14)
		: a_prod[29:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_s1   <= '0;
			u2_s1  <= '0;
			neg_s1 <= 1'b0;
			u_s2   <= '0;
			u2_s2  <= '0;
			t1_s2  <= '0;
			neg_s2 <= 1'b0;
			u_s3   <= '0;
			t2_s3  <= '0;
			neg_s3 <= 1'b0;
			sine   <= '0;
		end else begin
			u_s1   <= uu;
			u2_s1  <= sq[28:14];
			neg_s1 <= quad[1];
			u_s2   <= u_s1;
			u2_s2  <= u2_s1;
			t1_s2  <= vrp_pkg::SIN_B - 14'(c_prod[25:14]);
			neg_s2 <= neg_s1;
			u_s3   <= u_s2;
			t2_s3  <= vrp_pkg::SIN_A - 15'(b_prod[27:14]);
			neg_s3 <= neg_s2;
			sine   <= neg_s3 ? -$signed(mag) : $signed(mag);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/vrp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module vrp_div #(
	parameter int NB  = 40,
	parameter int DB  = 24,
	parameter int SBW = 1
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             en,
	input  wire  [NB-1:0]   num,
	input  wire  [DB-1:0]   den,
	input  wire  [SBW-1:0]  sb_in,
	output logic [NB-1:0]   quo,
	output logic [SBW-1:0]  sb_out
);
	logic [DB-1:0]  rem_r [NB+1];
	logic [NB-1:0]  num_r [NB+1];
	logic [NB-1:0]  quo_r [NB+1];
	logic [DB-1:0]  den_r [NB+1];
	logic [SBW-1:0] sb_r  [NB+1];

	assign rem_r[0] = '0;
	assign num_r[0] = num;
	assign quo_r[0] = '0;
	assign den_r[0] = den;
	assign sb_r[0]  = sb_in;

	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic [DB:0] trial;
		logic        ge;
		assign trial = {rem_r[k], num_r[k][NB-1]};
		assign ge    = trial >= {1'b0, den_r[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rem_r[k+1] <= '0;
				num_r[k+1] <= '0;
				quo_r[k+1] <= '0;
				den_r[k+1] <= '0;
				sb_r[k+1]  <= '0;
			end else if (en) begin
				rem_r[k+1] <= ge ? DB'(trial - {1'b0, den_r[k]}) : DB'(trial);
				num_r[k+1] <= num_r[k] << 1;
				quo_r[k+1] <= {quo_r[k][NB-2:0], ge};
				den_r[k+1] <= den_r[k];
				sb_r[k+1]  <= sb_r[k];
			end
		end
	end

	assign quo    = quo_r[NB];
	assign sb_out = sb_r[NB];
endmodule
`default_nettype wire

// ----- rtl/vrp_front.sv -----
// Front end: config registers, trig units and the input vertex queue.
`timescale 1ns / 1ps
`default_nettype none
module vrp_front #(
	parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_BITS  = vrp_pkg::ANGLE_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [vrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [vrp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                push,
	output logic                               full,
	input  wire  signed [COORD_WIDTH-1:0]      vertex_x,
	input  wire  signed [COORD_WIDTH-1:0]      vertex_y,
	input  wire  signed [COORD_WIDTH-1:0]      vertex_z,
	output logic                               f_valid,
	input  wire                                f_take,
	output logic [3*COORD_WIDTH-1:0]           f_data,
	output vrp_pkg::coef_t                     coef
);
	localparam int QD = 4;
	localparam int SW = $clog2(vrp_pkg::SETTLE_CYCLES + 1);

	logic [vrp_pkg::ANGLE_W-1:0]  angle_x_q, angle_y_q, angle_z_q;
	logic [vrp_pkg::DEPTH_W-1:0]  camera_depth_q;
	logic [vrp_pkg::SCALE_W-1:0]  scale_h_q, scale_v_q;
	logic [vrp_pkg::CENTER_W-1:0] center_h_q, center_v_q;
	logic [SW-1:0]                settle_q;
	logic [3*COORD_WIDTH-1:0]     mem_q [QD];
	logic [1:0]                   wptr_q, rptr_q;
	logic [2:0]                   cnt_q;
	logic                         do_push, do_pop;
	logic [ANGLE_BITS-1:0]        ax, ay, az;
	logic [ANGLE_BITS-1:0]        quarter;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_x_q      <= '0;
			angle_y_q      <= '0;
			angle_z_q      <= '0;
			camera_depth_q <= vrp_pkg::CAMERA_DEPTH_RST;
			scale_h_q      <= vrp_pkg::SCALE_H_RST;
			scale_v_q      <= vrp_pkg::SCALE_V_RST;
			center_h_q     <= vrp_pkg::CENTER_H_RST;
			center_v_q     <= vrp_pkg::CENTER_V_RST;
			settle_q       <= SW'(vrp_pkg::SETTLE_CYCLES);
		end else begin
			if (cfg_we) begin
				settle_q <= SW'(vrp_pkg::SETTLE_CYCLES);
				case (vrp_pkg::reg_idx_t'(cfg_index))
					vrp_pkg::REG_ANGLE_X:      angle_x_q <= cfg_data[vrp_pkg::ANGLE_W-1:0];
					vrp_pkg::REG_ANGLE_Y:      angle_y_q <= cfg_data[vrp_pkg::ANGLE_W-1:0];
					vrp_pkg::REG_ANGLE_Z:      angle_z_q <= cfg_data[vrp_pkg::ANGLE_W-1:0];
					vrp_pkg::REG_CAMERA_DEPTH: camera_depth_q <= cfg_data;
					vrp_pkg::REG_SCALE_H:      scale_h_q <= cfg_data;
					vrp_pkg::REG_SCALE_V:      scale_v_q <= cfg_data;
					vrp_pkg::REG_CENTER_H:     center_h_q <= cfg_data[vrp_pkg::CENTER_W-1:0];
					vrp_pkg::REG_CENTER_V:     center_v_q <= cfg_data[vrp_pkg::CENTER_W-1:0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SW'(1);
			end
		end
	end

	assign ax      = ANGLE_BITS'(angle_x_q);
	assign ay      = ANGLE_BITS'(angle_y_q);
	assign az      = ANGLE_BITS'(angle_z_q);
	assign quarter = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	vrp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_x (
		.clk(clk), .arst_n(arst_n), .angle(ax), .sine(coef.sin_x));
	vrp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_x (
		.clk(clk), .arst_n(arst_n), .angle(ax + quarter), .sine(coef.cos_x));
	vrp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_y (
		.clk(clk), .arst_n(arst_n), .angle(ay), .sine(coef.sin_y));
	vrp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_y (
		.clk(clk), .arst_n(arst_n), .angle(ay + quarter), .sine(coef.cos_y));
	vrp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_z (
		.clk(clk), .arst_n(arst_n), .angle(az), .sine(coef.sin_z));
	vrp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_z (
		.clk(clk), .arst_n(arst_n), .angle(az + quarter), .sine(coef.cos_z));

	assign coef.camera_depth = $signed(camera_depth_q);
	assign coef.scale_h      = scale_h_q;
	assign coef.scale_v      = scale_v_q;
	assign coef.center_h     = center_h_q;
	assign coef.center_v     = center_v_q;

	// input queue
	assign full    = (cnt_q == 3'(QD)) || (settle_q != '0);
	assign do_push = push && !full;
	assign f_valid = cnt_q != '0;
	assign do_pop  = f_take && f_valid;
	assign f_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= {vertex_x, vertex_y, vertex_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 2'd1;
			if (do_pop)  rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/vrp_back.sv -----
// Back end: rotation and projection pipeline with the result queue.
`timescale 1ns / 1ps
`default_nettype none
module vrp_back #(
	parameter int COORD_WIDTH = vrp_pkg::COORD_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           f_valid,
	output logic                          f_take,
	input  wire  [3*COORD_WIDTH-1:0]      f_data,
	input  vrp_pkg::coef_t                coef,
	output logic                          empty,
	input  wire                           pop,
	output logic signed [COORD_WIDTH-1:0] screen_x,
	output logic signed [COORD_WIDTH-1:0] screen_y,
	output logic signed [COORD_WIDTH-1:0] view_depth,
	output logic                          behind_camera
);
	localparam int W  = COORD_WIDTH;
	localparam int RW = W + 3;
	localparam int PW = RW + 16;
	localparam int DW = ((RW > vrp_pkg::DEPTH_W) ? RW : vrp_pkg::DEPTH_W) + 1;
	localparam int MW = RW + 17;
	localparam int NB = (((MW + 1) > (DW + 4)) ? (MW + 1) : (DW + 4)) + 1;
	localparam int DB = DW + 4;
	localparam int XW = NB + 2;
	localparam int SBX = W + 3;
	localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);
	localparam logic signed [DW-1:0] DSAT_HI = DW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [DW-1:0] DSAT_LO = -DSAT_HI - DW'(1);
	localparam logic signed [PW:0]   HALF = (PW+1)'(8192);

	logic adv;
	logic v_s0, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [RW-1:0] x_s0, y_s0, z_s0;
	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [RW-1:0] z_s1, x_s2, y_s2, z_s2;
	logic signed [PW-1:0] p0_s3, p1_s3, p2_s3, p3_s3;
	logic signed [RW-1:0] y_s3, x_s4, y_s4, z_s4;
	logic signed [PW-1:0] p0_s5, p1_s5, p2_s5, p3_s5;
	logic signed [RW-1:0] x_s5, x_s6, y_s6, z_s6;
	logic signed [DW-1:0] depth_s7;
	logic signed [MW-1:0] nx_s7, ny_s7;
	logic [NB-1:0]        numx_s8, numy_s8;
	logic [DB-1:0]        den_s8;
	logic                 sgx_s8, sgy_s8, beh_s8;
	logic signed [W-1:0]  vd_s8;
	logic signed [PW:0]   sa, sb, sc, sd;
	logic [MW-1:0]        magx, magy;
	logic                 beh7;
	logic signed [DW-1:0] dpos;
	logic [NB-1:0]        qx, qy;
	logic [SBX-1:0]       sbx_out;
	logic                 sgy_out;
	logic                 v_o, beh_o, sgx_o;
	logic signed [W-1:0]  vd_o;
	logic signed [XW-1:0] px, py, fx, fy;
	logic signed [W-1:0]  res_x, res_y;
	logic [3*W:0]         oq_q [2];
	logic                 owp_q, orp_q;
	logic [1:0]           ocnt_q;
	logic                 ofull, opush, opop;

	function automatic logic signed [RW-1:0] rnd(input logic signed [PW:0] v);
		logic signed [PW:0] t;
		t = v + HALF;
		return t[RW+13:14];
	endfunction

	assign ofull  = ocnt_q == 2'd2;
	assign adv    = !(v_o && ofull);
	assign f_take = adv && f_valid;

	assign sa = (PW+1)'(p0_s1) - (PW+1)'(p1_s1);
	assign sb = (PW+1)'(p2_s1) + (PW+1)'(p3_s1);
	assign sc = (PW+1)'(p0_s3) + (PW+1)'(p1_s3);
	assign sd = (PW+1)'(p2_s3) - (PW+1)'(p3_s3);

	assign beh7 = depth_s7 <= 0;
	assign dpos = beh7 ? DW'(1) : depth_s7;
	assign magx = nx_s7[MW-1] ? MW'(-nx_s7) : MW'(nx_s7);
	assign magy = ny_s7[MW-1] ? MW'(-ny_s7) : MW'(ny_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0; v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (adv) begin
			v_s0 <= f_take;
			v_s1 <= v_s0; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s0 <= RW'($signed(f_data[3*W-1:2*W]));
			y_s0 <= RW'($signed(f_data[2*W-1:W]));
			z_s0 <= RW'($signed(f_data[W-1:0]));
			// about z
			p0_s1 <= x_s0 * coef.cos_z;
			p1_s1 <= y_s0 * coef.sin_z;
			p2_s1 <= x_s0 * coef.sin_z;
			p3_s1 <= y_s0 * coef.cos_z;
			z_s1  <= z_s0;
			x_s2  <= rnd(sa);
			y_s2  <= rnd(sb);
			z_s2  <= z_s1;
			// about y
			p0_s3 <= x_s2 * coef.cos_y;
			p1_s3 <= z_s2 * coef.sin_y;
			p2_s3 <= z_s2 * coef.cos_y;
			p3_s3 <= x_s2 * coef.sin_y;
			y_s3  <= y_s2;
			x_s4  <= rnd(sc);
			z_s4  <= rnd(sd);
			y_s4  <= y_s3;
			// about x
			p0_s5 <= y_s4 * coef.cos_x;
			p1_s5 <= z_s4 * coef.sin_x;
			p2_s5 <= y_s4 * coef.sin_x;
			p3_s5 <= z_s4 * coef.cos_x;
			x_s5  <= x_s4;
			y_s6  <= rnd((PW+1)'(p0_s5) - (PW+1)'(p1_s5));
			z_s6  <= rnd((PW+1)'(p2_s5) + (PW+1)'(p3_s5));
			x_s6  <= x_s5;
			// depth and focal scale
			depth_s7 <= DW'(coef.camera_depth) - DW'(z_s6);
			nx_s7    <= x_s6 * $signed({1'b0, coef.scale_h});
			ny_s7    <= y_s6 * $signed({1'b0, coef.scale_v});
			// divider operands: round(mag / (16 d)) = (2 mag + 16 d) / (32 d)
			numx_s8 <= (NB'(magx) << 1) + (NB'(dpos) << 4);
			numy_s8 <= (NB'(magy) << 1) + (NB'(dpos) << 4);
			den_s8  <= DB'(dpos) << 5;
			sgx_s8  <= nx_s7[MW-1];
			sgy_s8  <= ny_s7[MW-1];
			beh_s8  <= beh7;
			vd_s8   <= (depth_s7 > DSAT_HI) ? W'(DSAT_HI)
				: (depth_s7 < DSAT_LO) ? W'(DSAT_LO) : W'(depth_s7);
		end
	end

	vrp_div #(.NB(NB), .DB(DB), .SBW(SBX)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(numx_s8), .den(den_s8),
		.sb_in({v_s8, beh_s8, sgx_s8, vd_s8}),
		.quo(qx), .sb_out(sbx_out));

	vrp_div #(.NB(NB), .DB(DB), .SBW(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(numy_s8), .den(den_s8),
		.sb_in(sgy_s8),
		.quo(qy), .sb_out(sgy_out));

	assign {v_o, beh_o, sgx_o, vd_o} = sbx_out;

	assign px = sgx_o ? -XW'(qx) : XW'(qx);
	assign py = sgy_out ? -XW'(qy) : XW'(qy);
	assign fx = px + XW'({coef.center_h, 4'b0});
	assign fy = XW'({coef.center_v, 4'b0}) - py;

	always_comb begin
		res_x = (fx > SAT_HI) ? W'(SAT_HI) : (fx < SAT_LO) ? W'(SAT_LO) : W'(fx);
		res_y = (fy > SAT_HI) ? W'(SAT_HI) : (fy < SAT_LO) ? W'(SAT_LO) : W'(fy);
		if (beh_o) begin
			res_x = '0;
			res_y = '0;
		end
	end

	// result queue
	assign opush = v_o && !ofull;
	assign empty = ocnt_q == 2'd0;
	assign opop  = pop && !empty;
	assign {screen_x, screen_y, view_depth, behind_camera} = oq_q[orp_q];

	always_ff @(posedge clk) begin
		if (opush) begin
			oq_q[owp_q] <= {res_x, res_y, vd_o, beh_o};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (opush) owp_q <= !owp_q;
			if (opop)  orp_q <= !orp_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
		end
	end
endmodule
`default_nettype wire
